// ===== src/gpb_pkg.sv =====
// ---------------------------------------------------------------------------
// gpb_pkg
// Shared constants, register codes and word types of the glyph pixel blitter.
// ---------------------------------------------------------------------------
package gpb_pkg;

  localparam int GLYPH_WIDTH  = 8;
  localparam int GLYPH_HEIGHT = 16;
  localparam int MAX_MAGNIFY  = 8;

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // register indexes on the configuration channel
  typedef enum logic [2:0] {
    REG_CANVAS_WIDTH   = 3'd0,
    REG_CANVAS_HEIGHT  = 3'd1,
    REG_ROW_STRIDE     = 3'd2,
    REG_BITS_PER_PIXEL = 3'd3,
    REG_FLIP_VERTICAL  = 3'd4,
    REG_FLIP_HORIZ     = 3'd5,
    REG_MSB_FIRST      = 3'd6,
    REG_TRANSPARENT    = 3'd7
  } cfg_reg_t;

  localparam logic [10:0] RST_CANVAS_WIDTH  = 11'd400;
  localparam logic [10:0] RST_CANVAS_HEIGHT = 11'd300;
  localparam logic [10:0] RST_ROW_STRIDE    = 11'd50;
  localparam logic [3:0]  RST_BPP           = 4'd1;
  localparam logic [7:0]  RST_TRANSPARENT   = 8'd255;

  typedef struct packed {
    logic [10:0] width;
    logic [10:0] height;
    logic [10:0] stride;
    logic [3:0]  bpp;
    logic        flip_v;
    logic        flip_h;
    logic        msb_first;
    logic [7:0]  transparent;
  } cfg_t;

  // one classified glyph pixel: square origin and surviving row/column spans
  typedef struct packed {
    logic signed [12:0] row0;
    logic signed [12:0] col0;
    logic [2:0]         row_lo;
    logic [2:0]         row_hi;
    logic [2:0]         col_lo;
    logic [2:0]         col_hi;
    logic [7:0]         color;
  } entry_t;

endpackage

// ===== src/gpb_front.sv =====
// ---------------------------------------------------------------------------
// gpb_front
// Accepts glyph pixels, drops empty ones, works out the clipped square span.
// ---------------------------------------------------------------------------
module gpb_front (
  input  logic                 start,
  output logic                 busy,
  input  logic signed [10:0]   origin_x,
  input  logic signed [10:0]   origin_y,
  input  logic [3:0]           glyph_row,
  input  logic [2:0]           glyph_col,
  input  logic                 pixel_on,
  input  logic [7:0]           fore_color,
  input  logic [7:0]           back_color,
  input  logic [3:0]           magnify,
  input  gpb_pkg::cfg_t        cfg,
  input  logic                 q_full,
  output logic                 q_push,
  output gpb_pkg::entry_t      q_din
);

  typedef struct packed {
    logic       ok;
    logic [2:0] lo;
    logic [2:0] hi;
  } span_t;

  // offsets mr in 0..mag-1 with 0 <= base+mr < limit form one run
  function automatic span_t span(input logic signed [12:0] base,
                                 input logic [10:0] limit,
                                 input logic [3:0] mag);
    logic signed [13:0] lo;
    logic signed [13:0] hi;
    logic signed [13:0] hi_mag;
    logic signed [13:0] hi_lim;
    span_t s;
    lo     = (base < 0) ? -14'(base) : 14'sd0;
    hi_mag = $signed({10'b0, mag}) - 14'sd1;
    hi_lim = $signed({3'b0, limit}) - 14'sd1 - 14'(base);
    hi     = (hi_mag < hi_lim) ? hi_mag : hi_lim;
    s.ok   = (mag != 4'd0) && (lo <= hi);
    s.lo   = lo[2:0];
    s.hi   = hi[2:0];
    return s;
  endfunction

  logic [3:0]         mag_eff;
  logic [7:0]         prod_r;
  logic [6:0]         prod_c;
  logic signed [12:0] row0;
  logic signed [12:0] col0;
  logic [7:0]         color;
  logic               in_cell;
  span_t              rspan;
  span_t              cspan;

  assign busy    = q_full;
  assign mag_eff = (magnify > 4'(gpb_pkg::MAX_MAGNIFY)) ? 4'(gpb_pkg::MAX_MAGNIFY) : magnify;
  assign prod_r  = glyph_row * mag_eff;
  assign prod_c  = glyph_col * mag_eff;
  assign row0    = $signed({5'b0, prod_r}) + 13'(origin_y);
  assign col0    = $signed({6'b0, prod_c}) + 13'(origin_x);
  assign color   = pixel_on ? fore_color : back_color;
  assign in_cell = (6'(glyph_row) < 6'(gpb_pkg::GLYPH_HEIGHT)) &&
                   (6'(glyph_col) < 6'(gpb_pkg::GLYPH_WIDTH));
  assign rspan   = span(row0, cfg.height, mag_eff);
  assign cspan   = span(col0, cfg.width, mag_eff);

  always_comb begin
    q_push        = start && !q_full && in_cell && (color != cfg.transparent) &&
                    rspan.ok && cspan.ok;
    q_din.row0    = row0;
    q_din.col0    = col0;
    q_din.row_lo  = rspan.lo;
    q_din.row_hi  = rspan.hi;
    q_din.col_lo  = cspan.lo;
    q_din.col_hi  = cspan.hi;
    q_din.color   = color;
  end

endmodule

// ===== src/gpb_queue.sv =====
// ---------------------------------------------------------------------------
// gpb_queue
// Short first-in first-out queue between the front and the back.
// ---------------------------------------------------------------------------
module gpb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gpb_pkg::entry_t din,
  input  logic            pop,
  output gpb_pkg::entry_t dout,
  output logic            not_empty,
  output logic            full
);

  localparam int CNT_W = $clog2(gpb_pkg::QUEUE_DEPTH + 1);

  gpb_pkg::entry_t              mem [gpb_pkg::QUEUE_DEPTH];
  logic [gpb_pkg::QPTR_W-1:0]   wr_ptr;
  logic [gpb_pkg::QPTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]             count;

  assign not_empty = (count != '0);
  assign full      = (count == CNT_W'(gpb_pkg::QUEUE_DEPTH));
  assign dout      = mem[rd_ptr];

  function automatic logic [gpb_pkg::QPTR_W-1:0] incr(input logic [gpb_pkg::QPTR_W-1:0] p);
    return (p == gpb_pkg::QPTR_W'(gpb_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= incr(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= incr(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/gpb_back.sv =====
// ---------------------------------------------------------------------------
// gpb_back
// Walks the surviving square one pixel a cycle and formats the masked writes.
// ---------------------------------------------------------------------------
module gpb_back (
  input  logic            clk,
  input  logic            rst,
  input  gpb_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  gpb_pkg::entry_t q_dout,
  output logic            q_pop,
  output logic            write_strobe,
  output logic [19:0]     byte_address,
  output logic [7:0]      bit_mask,
  output logic [7:0]      write_bits,
  output logic            last
);

  // walker
  gpb_pkg::entry_t cur;
  logic            active;
  logic [2:0]      mr;
  logic [2:0]      mc;
  logic            row_end;
  logic            done;

  // stage 1: mirrored canvas position
  logic            s1_valid;
  logic [10:0]     s1_row;
  logic [10:0]     s1_col;
  logic [7:0]      s1_color;
  logic            s1_last;

  logic signed [12:0] r_sum;
  logic signed [12:0] c_sum;
  logic [10:0]        r_next;
  logic [10:0]        c_next;

  // stage 2 terms
  logic [3:0]         bpp;
  logic [7:0]         pmask;
  logic [13:0]        bitpos;
  logic [21:0]        addr_full;
  logic signed [4:0]  pos;

  function automatic logic [7:0] place(input logic [7:0] v, input logic signed [4:0] p);
    logic [15:0] wide;
    logic [3:0]  amt;
    wide = 16'(v);
    if (p >= 0) begin
      amt = 4'(p);
      return 8'(wide << amt);
    end else begin
      amt = 4'(-p);
      return 8'(wide >> amt);
    end
  endfunction

  assign row_end = (mc == cur.col_hi);
  assign done    = active && row_end && (mr == cur.row_hi);
  assign q_pop   = q_valid && (!active || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (q_pop) begin
      active <= 1'b1;
    end else if (done) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_dout;
      mr  <= q_dout.row_lo;
      mc  <= q_dout.col_lo;
    end else if (active) begin
      if (row_end) begin
        mr <= mr + 1'b1;
        mc <= cur.col_lo;
      end else begin
        mc <= mc + 1'b1;
      end
    end
  end

  assign r_sum  = cur.row0 + $signed({10'b0, mr});
  assign c_sum  = cur.col0 + $signed({10'b0, mc});
  assign r_next = cfg.flip_v ? (cfg.height - r_sum[10:0] - 11'd1) : r_sum[10:0];
  assign c_next = cfg.flip_h ? (cfg.width - c_sum[10:0] - 11'd1) : c_sum[10:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    s1_row   <= r_next;
    s1_col   <= c_next;
    s1_color <= cur.color;
    s1_last  <= done;
  end

  // depth 0 acts as 1, above 8 as 8
  assign bpp       = (cfg.bpp == 4'd0) ? 4'd1 : ((cfg.bpp > 4'd8) ? 4'd8 : cfg.bpp);
  assign pmask     = 8'((9'd1 << bpp) - 9'd1);
  assign bitpos    = s1_col * bpp;
  assign addr_full = (s1_row * cfg.stride) + 22'(bitpos[13:3]);
  assign pos       = cfg.msb_first ? (5'sd8 - $signed({2'b0, bitpos[2:0]}) -
                                      $signed({1'b0, bpp}))
                                   : $signed({2'b0, bitpos[2:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      write_strobe <= 1'b0;
    end else begin
      write_strobe <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    byte_address <= addr_full[19:0];
    bit_mask     <= place(pmask, pos);
    write_bits   <= place(s1_color & pmask, pos);
    last         <= s1_last;
  end

endmodule

// ===== src/glyph_pixel_blitter.sv =====
// ---------------------------------------------------------------------------
// glyph_pixel_blitter
// Magnified glyph pixel writer: one glyph pixel in, masked byte writes out.
// ---------------------------------------------------------------------------
// Use:
//   A glyph pixel word is taken at a clock edge with start high and busy low.
//   busy only rises while the two-word queue between front and back is full.
//   The front classifies the word in the cycle it is taken: transparent,
//   zero-magnify, out-of-cell and fully clipped pixels are dropped there.
//   The back walks the clipped square row by row, one canvas pixel a cycle,
//   and emits a write word (byte_address, bit_mask, write_bits, last) for one
//   cycle with write_strobe high; last marks the final word of a pixel.
//   With the back idle, the taken pixel is popped from the queue into the
//   walker and passes the position and format registers before write_strobe
//   rises. The back spends a pixel's walk only on its surviving canvas
//   pixels, so an unclipped square of magnify * magnify pixels (one to 64)
//   takes longest; dropped pixels never reach the back and pass at one a
//   cycle while the queue has room.
//   The back walker, running one position a cycle, sets the sustained rate.
//   The receiver cannot stall: every write word must be taken as shown.
//   Configuration: cfg_valid/cfg_index/cfg_data, always ready; write only
//   while idle. Reset clears the queue and walker and loads register defaults.
// ---------------------------------------------------------------------------
module glyph_pixel_blitter (
  input  logic                clk,
  input  logic                rst,
  // pixel channel
  input  logic                start,
  output logic                busy,
  input  logic signed [10:0]  origin_x,
  input  logic signed [10:0]  origin_y,
  input  logic [3:0]          glyph_row,
  input  logic [2:0]          glyph_col,
  input  logic                pixel_on,
  input  logic [7:0]          fore_color,
  input  logic [7:0]          back_color,
  input  logic [3:0]          magnify,
  // configuration channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [10:0]         cfg_data,
  // write channel
  output logic                write_strobe,
  output logic [19:0]         byte_address,
  output logic [7:0]          bit_mask,
  output logic [7:0]          write_bits,
  output logic                last
);

  gpb_pkg::cfg_t   cfg;
  gpb_pkg::entry_t q_din;
  gpb_pkg::entry_t q_dout;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  logic            q_full;

  // register file: writes always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width       <= gpb_pkg::RST_CANVAS_WIDTH;
      cfg.height      <= gpb_pkg::RST_CANVAS_HEIGHT;
      cfg.stride      <= gpb_pkg::RST_ROW_STRIDE;
      cfg.bpp         <= gpb_pkg::RST_BPP;
      cfg.flip_v      <= 1'b0;
      cfg.flip_h      <= 1'b0;
      cfg.msb_first   <= 1'b1;
      cfg.transparent <= gpb_pkg::RST_TRANSPARENT;
    end else if (cfg_valid && cfg_ready) begin
      case (gpb_pkg::cfg_reg_t'(cfg_index))
        gpb_pkg::REG_CANVAS_WIDTH:   cfg.width       <= cfg_data;
        gpb_pkg::REG_CANVAS_HEIGHT:  cfg.height      <= cfg_data;
        gpb_pkg::REG_ROW_STRIDE:     cfg.stride      <= cfg_data;
        gpb_pkg::REG_BITS_PER_PIXEL: cfg.bpp         <= cfg_data[3:0];
        gpb_pkg::REG_FLIP_VERTICAL:  cfg.flip_v      <= cfg_data[0];
        gpb_pkg::REG_FLIP_HORIZ:     cfg.flip_h      <= cfg_data[0];
        gpb_pkg::REG_MSB_FIRST:      cfg.msb_first   <= cfg_data[0];
        gpb_pkg::REG_TRANSPARENT:    cfg.transparent <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // front: classify and clip spans
  gpb_front u_front (
    .start      (start),
    .busy       (busy),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .glyph_row  (glyph_row),
    .glyph_col  (glyph_col),
    .pixel_on   (pixel_on),
    .fore_color (fore_color),
    .back_color (back_color),
    .magnify    (magnify),
    .cfg        (cfg),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_din      (q_din)
  );

  gpb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .din       (q_din),
    .pop       (q_pop),
    .dout      (q_dout),
    .not_empty (q_valid),
    .full      (q_full)
  );

  // back: square walk, mirroring, address and mask formatting
  gpb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_dout       (q_dout),
    .q_pop        (q_pop),
    .write_strobe (write_strobe),
    .byte_address (byte_address),
    .bit_mask     (bit_mask),
    .write_bits   (write_bits),
    .last         (last)
  );

endmodule

// ===== src/gpb_checker.sv =====
// ---------------------------------------------------------------------------
// gpb_checker
// Port-level checks of the glyph pixel blitter, bound to the top level.
// ---------------------------------------------------------------------------
module gpb_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        cfg_ready,
  input logic        write_strobe,
  input logic [7:0]  bit_mask,
  input logic [7:0]  write_bits
);

  // nothing in flight survives reset, and the pipeline needs time to refill
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !write_strobe ##1 !write_strobe ##1 !write_strobe)
    else $error("write word too soon after reset");

  // queue is empty after reset
  a_free_after_reset: assert property (@(posedge clk)
    rst |=> !busy)
    else $error("busy straight after reset");

  // colour bits never fall outside the pixel's mask
  a_bits_in_mask: assert property (@(posedge clk) disable iff (rst)
    write_strobe |-> ((write_bits & ~bit_mask) == 8'd0))
    else $error("write bits outside mask");

  // register port never holds writes off
  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind glyph_pixel_blitter gpb_port_checks u_gpb_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .cfg_ready    (cfg_ready),
  .write_strobe (write_strobe),
  .bit_mask     (bit_mask),
  .write_bits   (write_bits)
);

// ===== sim/gpb_checker.sv =====
// ---------------------------------------------------------------------------
// gpb_checker
// Watches the pixel, configuration and write channels of the blitter, keeps
// its own copy of the registers, expands each taken glyph pixel into the
// write words it must cause and compares every write word as it appears.
// ---------------------------------------------------------------------------
module gpb_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [10:0] origin_x,
  input  logic signed [10:0] origin_y,
  input  logic [3:0]         glyph_row,
  input  logic [2:0]         glyph_col,
  input  logic               pixel_on,
  input  logic [7:0]         fore_color,
  input  logic [7:0]         back_color,
  input  logic [3:0]         magnify,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [10:0]        cfg_data,
  input  logic               write_strobe,
  input  logic [19:0]        byte_address,
  input  logic [7:0]         bit_mask,
  input  logic [7:0]         write_bits,
  input  logic               last,
  output int                 mismatches,
  output int                 pending_words,
  output int                 words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [19:0] addr;
    logic [7:0]  mask;
    logic [7:0]  bits;
    logic        last;
  } write_word_t;

  gpb_pkg::cfg_t shadow_regs;
  write_word_t   expected_writes[$];

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40)
      $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // value placed at a signed bit position, low byte kept
  function automatic logic [7:0] place_bits(int value, int pos);
    if (pos >= 0)
      return 8'((value << pos) & 'hFF);
    return 8'((value >> (-pos)) & 'hFF);
  endfunction

  function automatic void expand_pixel(int ox, int oy, int grow, int gcol, logic on,
                                       int fore, int back, int mag);
    int          colour, bpp, pmask, w, h, r, c, bitpos, ofs;
    write_word_t held;
    bit          have_held;
    colour    = on ? fore : back;
    have_held = 1'b0;
    held      = '0;
    if (colour == int'(shadow_regs.transparent))
      return;
    if (grow >= gpb_pkg::GLYPH_HEIGHT || gcol >= gpb_pkg::GLYPH_WIDTH)
      return;
    if (mag > gpb_pkg::MAX_MAGNIFY)
      mag = gpb_pkg::MAX_MAGNIFY;
    bpp = int'(shadow_regs.bpp);
    if (bpp == 0)
      bpp = 1;
    if (bpp > 8)
      bpp = 8;
    pmask = (1 << bpp) - 1;
    w     = int'(shadow_regs.width);
    h     = int'(shadow_regs.height);
    for (int mr = 0; mr < mag; mr++) begin
      r = grow * mag + mr + oy;
      if (r < 0 || r >= h)
        continue;
      if (shadow_regs.flip_v)
        r = h - r - 1;
      for (int mc = 0; mc < mag; mc++) begin
        c = gcol * mag + mc + ox;
        if (c < 0 || c >= w)
          continue;
        if (shadow_regs.flip_h)
          c = w - c - 1;
        bitpos = c * bpp;
        ofs    = bitpos % 8;
        if (shadow_regs.msb_first)
          ofs = 8 - ofs - bpp;
        // hold one word back so the final one can carry last
        if (have_held)
          expected_writes.push_back(held);
        held.addr = 20'(r * int'(shadow_regs.stride) + bitpos / 8);
        held.mask = place_bits(pmask, ofs);
        held.bits = place_bits(colour & pmask, ofs);
        held.last = 1'b0;
        have_held = 1'b1;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      expected_writes.push_back(held);
    end
  endfunction

  always @(posedge clk) begin : watch
    write_word_t want;
    if (rst) begin
      shadow_regs.width       = gpb_pkg::RST_CANVAS_WIDTH;
      shadow_regs.height      = gpb_pkg::RST_CANVAS_HEIGHT;
      shadow_regs.stride      = gpb_pkg::RST_ROW_STRIDE;
      shadow_regs.bpp         = gpb_pkg::RST_BPP;
      shadow_regs.flip_v      = 1'b0;
      shadow_regs.flip_h      = 1'b0;
      shadow_regs.msb_first   = 1'b1;
      shadow_regs.transparent = gpb_pkg::RST_TRANSPARENT;
      expected_writes.delete();
      mismatches    = 0;
      words_checked = 0;
    end else begin
      // results first: nothing taken at this edge can show up yet
      if (write_strobe !== 1'b0) begin
        if (expected_writes.size() == 0) begin
          flag_mismatch($sformatf("write word with none expected, address %05h",
                                  byte_address));
        end else begin
          want = expected_writes.pop_front();
          if (byte_address !== want.addr)
            flag_mismatch($sformatf("byte_address %05h, expected %05h",
                                    byte_address, want.addr));
          if (bit_mask !== want.mask)
            flag_mismatch($sformatf("bit_mask %02h, expected %02h (address %05h)",
                                    bit_mask, want.mask, want.addr));
          if (write_bits !== want.bits)
            flag_mismatch($sformatf("write_bits %02h, expected %02h (address %05h)",
                                    write_bits, want.bits, want.addr));
          if (last !== want.last)
            flag_mismatch($sformatf("last %b, expected %b (address %05h)",
                                    last, want.last, want.addr));
          words_checked++;
        end
      end
      if (start && !busy)
        expand_pixel(int'(origin_x), int'(origin_y), int'(glyph_row), int'(glyph_col),
                     pixel_on, int'(fore_color), int'(back_color), int'(magnify));
      if (cfg_valid && cfg_ready) begin
        case (gpb_pkg::cfg_reg_t'(cfg_index))
          gpb_pkg::REG_CANVAS_WIDTH:   shadow_regs.width       = cfg_data;
          gpb_pkg::REG_CANVAS_HEIGHT:  shadow_regs.height      = cfg_data;
          gpb_pkg::REG_ROW_STRIDE:     shadow_regs.stride      = cfg_data;
          gpb_pkg::REG_BITS_PER_PIXEL: shadow_regs.bpp         = cfg_data[3:0];
          gpb_pkg::REG_FLIP_VERTICAL:  shadow_regs.flip_v      = cfg_data[0];
          gpb_pkg::REG_FLIP_HORIZ:     shadow_regs.flip_h      = cfg_data[0];
          gpb_pkg::REG_MSB_FIRST:      shadow_regs.msb_first   = cfg_data[0];
          gpb_pkg::REG_TRANSPARENT:    shadow_regs.transparent = cfg_data[7:0];
          default: ;
        endcase
      end
    end
    pending_words <= expected_writes.size();
  end

endmodule

// ===== sim/tb_glyph_pixel_blitter.sv =====
// ---------------------------------------------------------------------------
// tb_glyph_pixel_blitter
// Drives glyph pixel words and register writes into the blitter; checking is
// done by gpb_checker, this module only makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module tb_glyph_pixel_blitter;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no word moved on any channel before giving up
  localparam int STALL_LIMIT = 2000;
  // quiet cycles after the last expected write word, well past the latency
  localparam int SETTLE_CYCLES = 8;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               start      = 1'b0;
  logic               busy;
  logic signed [10:0] origin_x   = '0;
  logic signed [10:0] origin_y   = '0;
  logic [3:0]         glyph_row  = '0;
  logic [2:0]         glyph_col  = '0;
  logic               pixel_on   = 1'b0;
  logic [7:0]         fore_color = '0;
  logic [7:0]         back_color = '0;
  logic [3:0]         magnify    = '0;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index  = '0;
  logic [10:0]        cfg_data   = '0;
  logic               write_strobe;
  logic [19:0]        byte_address;
  logic [7:0]         bit_mask;
  logic [7:0]         write_bits;
  logic               last;

  int mismatches;
  int pending_words;
  int words_checked;

  int pixels_sent    = 0;
  int settings_used  = 1;   // the reset values count as the first
  int stall_cycles   = 0;
  // what the stimulus knows of the canvas, to aim origins at it
  int cur_width      = 400;
  int cur_height     = 300;
  int cur_transparent = 255;

  glyph_pixel_blitter i_dut (.*);

  gpb_checker i_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog: any word moved on any channel resets the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || write_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Timeout: nothing moved for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // cfg_valid is left high here; setup_canvas lowers it once after the last
  // register so back-to-back writes never drop and raise it in one step
  task automatic write_reg(gpb_pkg::cfg_reg_t idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 11'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  // writes every register; only called with the block idle
  task automatic setup_canvas(int w, int h, int stride, int bpp,
                              int fv, int fh, int msb, int tr);
    write_reg(gpb_pkg::REG_CANVAS_WIDTH, w);
    write_reg(gpb_pkg::REG_CANVAS_HEIGHT, h);
    write_reg(gpb_pkg::REG_ROW_STRIDE, stride);
    write_reg(gpb_pkg::REG_BITS_PER_PIXEL, bpp);
    write_reg(gpb_pkg::REG_FLIP_VERTICAL, fv);
    write_reg(gpb_pkg::REG_FLIP_HORIZ, fh);
    write_reg(gpb_pkg::REG_MSB_FIRST, msb);
    write_reg(gpb_pkg::REG_TRANSPARENT, tr);
    cfg_valid       <= 1'b0;
    cur_width       = w;
    cur_height      = h;
    cur_transparent = tr;
    settings_used++;
  endtask

  task automatic random_setup();
    setup_canvas($urandom_range(8, 1024), $urandom_range(8, 1024),
                 $urandom_range(0, 1024), $urandom_range(0, 15),
                 $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(0, 255));
  endtask

  // start stays high after the word is taken; the caller lowers it if idling
  task automatic send_pixel(int ox, int oy, int row, int col, int on,
                            int fore, int back, int mag);
    origin_x   <= 11'(ox);
    origin_y   <= 11'(oy);
    glyph_row  <= 4'(row);
    glyph_col  <= 3'(col);
    pixel_on   <= 1'(on);
    fore_color <= 8'(fore);
    back_color <= 8'(back);
    magnify    <= 4'(mag);
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    pixels_sent++;
  endtask

  // sender idles each cycle with the given chance in a hundred, so gaps of
  // any length land anywhere in a square walk
  task automatic sender_pause(int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // let every expected write word come out, then give the front end time
  // to finish with words that cause none
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly origins near the canvas so squares land on it or its edges,
  // some across the full signed range; mostly small magnify
  task automatic send_random_pixel();
    int ox, oy, fore, back, mag, pick;
    pick = $urandom_range(99);
    if (pick < 5)
      mag = 0;
    else if (pick < 12)
      mag = $urandom_range(9, 15);
    else if (pick < 20)
      mag = 8;
    else
      mag = $urandom_range(1, 4);
    if ($urandom_range(9) == 0) begin
      ox = int'($urandom_range(0, 2047)) - 1024;
      oy = int'($urandom_range(0, 2047)) - 1024;
    end else begin
      ox = int'($urandom_range(0, cur_width + 40)) - 48;
      oy = int'($urandom_range(0, cur_height + 40)) - 48;
    end
    fore = $urandom_range(0, 255);
    back = $urandom_range(0, 255);
    pick = $urandom_range(9);
    if (pick == 0)
      fore = cur_transparent;
    else if (pick == 1)
      back = cur_transparent;
    send_pixel(ox, oy, $urandom_range(0, 15), $urandom_range(0, 7),
               $urandom_range(0, 1), fore, back, mag);
  endtask

  task automatic random_run(int count, int idle_pct);
    repeat (count) begin
      send_random_pixel();
      sender_pause(idle_pct);
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // --- directed, on the reset register values ---
    send_pixel(0, 0, 0, 0, 1, 8'h01, 8'h00, 1);          // single foreground pixel
    send_pixel(8, 0, 0, 1, 0, 8'h00, 8'h01, 1);          // background colour
    send_pixel(20, 4, 3, 2, 1, 8'hFF, 8'h00, 2);         // transparent foreground
    send_pixel(20, 4, 3, 2, 0, 8'h00, 8'hFF, 2);         // transparent background
    send_pixel(10, 10, 3, 3, 1, 8'h01, 8'h00, 0);        // no magnification
    send_pixel(100, 100, 15, 7, 1, 8'hFE, 8'h00, 8);     // largest square, far corner
    send_pixel(200, 50, 2, 5, 1, 8'h55, 8'h00, 15);      // magnify clamped to max
    send_pixel(-1024, -1024, 0, 0, 1, 8'h01, 8'h00, 8);  // wholly clipped, negative
    send_pixel(1023, 1023, 15, 7, 0, 8'h00, 8'hAA, 8);   // wholly clipped, positive
    send_pixel(-3, -2, 0, 0, 1, 8'h01, 8'h00, 4);        // clipped at left and top
    send_pixel(394, 294, 1, 1, 1, 8'h01, 8'h00, 4);      // clipped at right and bottom
    send_pixel(0, 0, 15, 7, 1, 8'h80, 8'h00, 3);
    drain();

    // odd depth, both mirrors, LSB first, colour zero transparent
    setup_canvas(400, 300, 50, 3, 1, 1, 0, 0);
    send_pixel(-3, -2, 0, 0, 1, 8'h05, 8'h00, 4);
    send_pixel(0, 0, 0, 7, 1, 8'hFF, 8'h00, 2);
    send_pixel(5, 5, 1, 1, 0, 8'h07, 8'h00, 2);          // transparent background
    drain();

    // odd depth MSB first: reversed offsets go negative, near top of address
    setup_canvas(1024, 1024, 1024, 7, 0, 0, 1, 255);
    send_pixel(1000, 1000, 1, 2, 1, 8'h7F, 8'h00, 8);
    send_pixel(3, 0, 0, 0, 0, 8'h00, 8'h6B, 3);
    drain();

    // zero depth taken as one bit
    setup_canvas(64, 32, 8, 0, 0, 1, 1, 255);
    send_pixel(60, 28, 0, 0, 1, 8'h01, 8'h00, 5);
    drain();

    // excess depth taken as eight bits
    setup_canvas(64, 32, 64, 15, 1, 0, 0, 255);
    send_pixel(-1, 30, 0, 0, 1, 8'hC3, 8'h00, 3);
    drain();

    // --- random phases, each under its own register setting ---
    setup_canvas(400, 300, 50, 1, 0, 0, 1, 255);
    random_run(40, 0);
    setup_canvas(1024, 1024, 1024, 8, 1, 1, 0, 0);
    random_run(40, 65);
    setup_canvas(0, 17, 0, 2, 0, 1, 1, 128);             // empty canvas
    random_run(12, 27);
    random_setup();
    random_run(40, 27);
    setup_canvas(1, 1, 1, 4, 1, 1, 0, 3);                // single-pixel canvas
    random_run(16, 65);
    random_setup();
    random_run(40, 0);
    random_setup();
    random_run(40, 65);

    $display("Sent %0d glyph pixels under %0d register settings, %0d write words checked.",
             pixels_sent, settings_used, words_checked);
    $display("Covered clipping, mirroring, transparency, depths 0 to 15, magnify 0 to 15.");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
